[hdl/htfd_pkg.sv]
// Shared types and constants for the humidity/temperature frame decoder.
package htfd_pkg;

  // CRC-8 over each data pair, MSB first, no final xor
  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'hFF;

  // Scaling: value = floor(GAIN * raw / 65535) - OFFSET
  localparam logic [16:0] DIV_BASE    = 17'h0FFFF;
  localparam logic [14:0] TEMP_GAIN   = 15'd17500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [13:0] HUM_GAIN    = 14'd12500;
  localparam logic [13:0] HUM_OFFSET  = 14'd600;
  localparam logic [13:0] HUM_MAX     = 14'd10000;

  // Position of the next byte within the six-byte reply
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } htfd_pos_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } htfd_in_t;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [13:0]        humidity_centi;
    logic               status;
  } htfd_out_t;

  // Frame tracker to top level: closing byte present, CRC failure flag and the assembled raw words
  typedef struct packed {
    logic        last;
    logic        bad;
    logic [15:0] raw_temp;
    logic [15:0] raw_hum;
  } htfd_frame_t;

endpackage

[hdl/humidity_temp_frame_decoder_top.sv]
// Top level of the humidity/temperature frame decoder: frame tracker, scaler, result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o    | rx_byte, frame_start
//  out     | output    | out_valid_o / out_stall_i  | temp_centi, humidity_centi, status
//
// One byte is taken every cycle while in_stall_o is low; each byte passes through the input register
// and the result of a sixth byte is loaded from there into the result register.
// Reset returns the byte position to the start of a frame and the CRC to 0xFF.
// A stall on the output only holds the input side when a sixth byte is waiting
// for a full result register; all other bytes keep flowing.
module humidity_temp_frame_decoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  htfd_pkg::htfd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output htfd_pkg::htfd_out_t out_data_o
);
  import htfd_pkg::*;

  htfd_frame_t        frame;
  logic               result_ready;
  logic               load;
  logic signed [14:0] temp_centi;
  logic [13:0]        humidity_centi;
  logic               out_valid_q, out_valid_d;
  htfd_out_t          out_data_q, out_data_d;

  // Result register can take a new transfer when empty or being drained
  assign result_ready = !out_valid_q || !out_stall_i;

  htfd_frame u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .result_ready_i (result_ready),
    .frame_o        (frame)
  );

  htfd_scale u_scale (
    .raw_temp_i       (frame.raw_temp),
    .raw_hum_i        (frame.raw_hum),
    .temp_centi_o     (temp_centi),
    .humidity_centi_o (humidity_centi)
  );

  assign load = frame.last && result_ready;

  // Zero both values on a CRC mismatch
  always_comb begin
    out_data_d = out_data_q;
    if (load) begin
      out_data_d.status         = frame.bad;
      out_data_d.temp_centi     = frame.bad ? '0 : temp_centi;
      out_data_d.humidity_centi = frame.bad ? '0 : humidity_centi;
    end
  end

  // Hold the result while stalled, drop it once the transfer completes
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[hdl/htfd_scale.sv]
// Fixed-point scaling of raw temperature and humidity words.
module htfd_scale (
  input  logic [15:0]        raw_temp_i,
  input  logic [15:0]        raw_hum_i,
  output logic signed [14:0] temp_centi_o,
  output logic [13:0]        humidity_centi_o
);
  import htfd_pkg::*;

  logic [30:0] prod_t;
  logic [14:0] q0_t;
  logic [16:0] r0_t;
  logic [14:0] q_t;
  logic [15:0] t_wide;

  logic [29:0] prod_h;
  logic [13:0] q0_h;
  logic [16:0] r0_h;
  logic [13:0] q_h;
  logic [13:0] h_sub;

  // x / 65535: x = q0*65536 + lo = q0*65535 + (q0 + lo); one correction suffices
  assign prod_t = {16'd0, TEMP_GAIN} * {15'd0, raw_temp_i};
  assign q0_t   = prod_t[30:16];
  assign r0_t   = {1'b0, prod_t[15:0]} + {2'd0, q0_t};
  assign q_t    = q0_t + {14'd0, (r0_t >= DIV_BASE)};
  assign t_wide = {1'b0, q_t} - TEMP_OFFSET;
  assign temp_centi_o = $signed(t_wide[14:0]);

  assign prod_h = {16'd0, HUM_GAIN} * {14'd0, raw_hum_i};
  assign q0_h   = prod_h[29:16];
  assign r0_h   = {1'b0, prod_h[15:0]} + {3'd0, q0_h};
  assign q_h    = q0_h + {13'd0, (r0_h >= DIV_BASE)};
  assign h_sub  = q_h - HUM_OFFSET;

  // Saturate to 0..HUM_MAX
  always_comb begin
    if (q_h < HUM_OFFSET) begin
      humidity_centi_o = '0;
    end else if (h_sub > HUM_MAX) begin
      humidity_centi_o = HUM_MAX;
    end else begin
      humidity_centi_o = h_sub;
    end
  end

endmodule

[hdl/htfd_frame.sv]
// Input register, byte position tracking and CRC checking of the reply frame.
module htfd_frame (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  htfd_pkg::htfd_in_t     in_data_i,
  input  logic                   result_ready_i,
  output htfd_pkg::htfd_frame_t  frame_o
);
  import htfd_pkg::*;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  logic        s1_valid_q, s1_valid_d;
  htfd_in_t    s1_data_q;
  htfd_pos_e   pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d, crc_base, crc_next;
  logic [15:0] raw_t_q, raw_t_d;
  logic [7:0]  hum_hi_q, hum_hi_d;
  logic [7:0]  hum_lo_q, hum_lo_d;
  logic        tbad_q, tbad_d;
  logic        is_last;
  logic        advance;
  logic        accept;
  logic [7:0]  b;

  assign b = s1_data_q.rx_byte;

  // Resync on frame_start or an unused position
  always_comb begin
    if (s1_data_q.frame_start) begin
      pos_eff = POS_T_HI;
    end else begin
      case (pos_q)
        POS_T_HI, POS_T_LO, POS_T_CRC, POS_H_HI, POS_H_LO, POS_H_CRC: pos_eff = pos_q;
        default: pos_eff = POS_T_HI;
      endcase
    end
  end

  assign crc_base = (pos_eff == POS_T_HI || pos_eff == POS_H_HI) ? CRC_INIT : crc_q;
  assign crc_next = crc8_byte(crc_base, b);

  assign is_last    = (pos_eff == POS_H_CRC);
  assign advance    = s1_valid_q && (!is_last || result_ready_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_valid_d = accept || (s1_valid_q && !advance);

  // Next state
  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    raw_t_d  = raw_t_q;
    hum_hi_d = hum_hi_q;
    hum_lo_d = hum_lo_q;
    tbad_d   = tbad_q;
    if (advance) begin
      case (pos_eff)
        POS_T_HI: begin
          crc_d   = crc_next;
          raw_t_d = {b, 8'h00};
          pos_d   = POS_T_LO;
        end
        POS_T_LO: begin
          crc_d   = crc_next;
          raw_t_d = {raw_t_q[15:8], b};
          pos_d   = POS_T_CRC;
        end
        POS_T_CRC: begin
          tbad_d = (crc_q != b);
          crc_d  = CRC_INIT;
          pos_d  = POS_H_HI;
        end
        POS_H_HI: begin
          crc_d    = crc_next;
          hum_hi_d = b;
          pos_d    = POS_H_LO;
        end
        POS_H_LO: begin
          crc_d    = crc_next;
          hum_lo_d = b;
          pos_d    = POS_H_CRC;
        end
        default: begin
          crc_d = CRC_INIT;
          pos_d = POS_T_HI;
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    frame_o.last     = s1_valid_q && is_last;
    frame_o.bad      = tbad_q || (crc_q != b);
    frame_o.raw_temp = raw_t_q;
    frame_o.raw_hum  = {hum_hi_q, hum_lo_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pos_q      <= POS_T_HI;
      crc_q      <= CRC_INIT;
      raw_t_q    <= '0;
      hum_hi_q   <= '0;
      hum_lo_q   <= '0;
      tbad_q     <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      pos_q      <= pos_d;
      crc_q      <= crc_d;
      raw_t_q    <= raw_t_d;
      hum_hi_q   <= hum_hi_d;
      hum_lo_q   <= hum_lo_d;
      tbad_q     <= tbad_d;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q <= in_data_i;
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the humidity/temperature frame decoder.
module testbench;
  import htfd_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 200000;
  localparam int IDLE_PCT     = 26;

  // Receiver hold-off: start once this many bytes went in, hold for this long
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;

  // Window of transfers with no idling on either side
  localparam int TX_QUIET_LO  = 450;
  localparam int TX_QUIET_HI  = 600;
  localparam int RX_QUIET_LO  = 450;
  localparam int RX_QUIET_HI  = 600;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_CRC_ERR = 1'b1;

  // Readings that can be read straight off the frame
  localparam htfd_out_t COLD_DRY = '{-15'sd4500, 14'd0, STATUS_OK};
  localparam htfd_out_t HOT_WET  = '{15'sd13000, 14'd10000, STATUS_OK};
  localparam htfd_out_t HOT_DRY  = '{15'sd13000, 14'd0, STATUS_OK};
  localparam htfd_out_t CRC_FAIL = '{15'sd0, 14'd0, STATUS_CRC_ERR};
  localparam htfd_out_t NO_READ  = '0;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  htfd_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  htfd_out_t out_data_o;

  humidity_temp_frame_decoder_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Directed stimulus. A row with typed set carries the reading it must close
  // with; all other rows are left to the frame tracker below.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [7:0] rx_byte;
    logic       frame_start;
    bit         typed;
    htfd_out_t  want;
  } dir_row_t;

  localparam int DIR_ROWS = 26;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // all-zero raw words: coldest temperature, humidity clamped up to zero
    '{8'h00, 1'b1, 1'b0, NO_READ},
    '{8'h00, 1'b0, 1'b0, NO_READ},
    '{8'h81, 1'b0, 1'b0, NO_READ},
    '{8'h00, 1'b0, 1'b0, NO_READ},
    '{8'h00, 1'b0, 1'b0, NO_READ},
    '{8'h81, 1'b0, 1'b1, COLD_DRY},
    // all-ones raw words, back to back without a frame start:
    // hottest temperature, humidity clamped down to full scale
    '{8'hFF, 1'b0, 1'b0, NO_READ},
    '{8'hFF, 1'b0, 1'b0, NO_READ},
    '{8'hAC, 1'b0, 1'b0, NO_READ},
    '{8'hFF, 1'b0, 1'b0, NO_READ},
    '{8'hFF, 1'b0, 1'b0, NO_READ},
    '{8'hAC, 1'b0, 1'b1, HOT_WET},
    // wrong temperature check byte, good humidity pair: whole reading fails
    '{8'hBE, 1'b0, 1'b0, NO_READ},
    '{8'hEF, 1'b0, 1'b0, NO_READ},
    '{8'h00, 1'b0, 1'b0, NO_READ},
    '{8'h00, 1'b0, 1'b0, NO_READ},
    '{8'h00, 1'b0, 1'b0, NO_READ},
    '{8'h81, 1'b0, 1'b1, CRC_FAIL},
    // abandon a frame after two bytes and start over mid-frame
    '{8'h5A, 1'b1, 1'b0, NO_READ},
    '{8'hA5, 1'b0, 1'b0, NO_READ},
    '{8'hFF, 1'b1, 1'b0, NO_READ},
    '{8'hFF, 1'b0, 1'b0, NO_READ},
    '{8'hAC, 1'b0, 1'b0, NO_READ},
    '{8'h00, 1'b0, 1'b0, NO_READ},
    '{8'h00, 1'b0, 1'b0, NO_READ},
    '{8'h81, 1'b0, 1'b1, HOT_DRY}
  };

  // ---------------------------------------------------------------------------
  // Frame tracker: mirrors the decoder state, one accepted byte at a time.
  // ---------------------------------------------------------------------------
  htfd_pos_e   trk_pos    = POS_T_HI;
  logic [7:0]  trk_crc    = CRC_INIT;
  logic [15:0] trk_raw_t  = '0;
  logic [7:0]  trk_hum_hi = '0;
  logic [7:0]  trk_hum_lo = '0;
  logic        trk_t_bad  = 1'b0;

  htfd_out_t pending_readings [$];
  int        items_sent = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Advance the tracker by one byte; flag a reading when the frame closes.
  task automatic track_byte(input htfd_in_t d, output bit closed, output htfd_out_t rd);
    htfd_pos_e   pos;
    logic        bad;
    int          temp;
    int          hum;
    logic [15:0] raw_h;
    pos    = d.frame_start ? POS_T_HI : trk_pos;
    closed = 1'b0;
    rd     = '0;
    case (pos)
      POS_T_HI: begin
        trk_crc   = crc8_step(CRC_INIT, d.rx_byte);
        trk_raw_t = {d.rx_byte, 8'h00};
      end
      POS_T_LO: begin
        trk_crc        = crc8_step(trk_crc, d.rx_byte);
        trk_raw_t[7:0] = d.rx_byte;
      end
      POS_T_CRC: begin
        trk_t_bad = (trk_crc != d.rx_byte);
        trk_crc   = CRC_INIT;
      end
      POS_H_HI: begin
        trk_crc    = crc8_step(CRC_INIT, d.rx_byte);
        trk_hum_hi = d.rx_byte;
      end
      POS_H_LO: begin
        trk_crc    = crc8_step(trk_crc, d.rx_byte);
        trk_hum_lo = d.rx_byte;
      end
      default: begin
        bad  = trk_t_bad || (trk_crc != d.rx_byte);
        temp = 0;
        hum  = 0;
        if (!bad) begin
          raw_h = {trk_hum_hi, trk_hum_lo};
          temp  = (17500 * int'(trk_raw_t)) / 65535 - 4500;
          hum   = (12500 * int'(raw_h)) / 65535 - 600;
          if (hum < 0) hum = 0;
          if (hum > 10000) hum = 10000;
        end
        rd.temp_centi     = 15'(temp);
        rd.humidity_centi = 14'(hum);
        rd.status         = bad ? STATUS_CRC_ERR : STATUS_OK;
        closed            = 1'b1;
      end
    endcase
    if (closed) begin
      trk_pos = POS_T_HI;
      trk_crc = CRC_INIT;
    end else begin
      trk_pos = htfd_pos_e'(pos + 3'd1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offer one byte, hold it until the transfer, then track it.
  // ---------------------------------------------------------------------------
  function automatic bit tx_idle();
    if (items_sent >= TX_QUIET_LO && items_sent < TX_QUIET_HI) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic start,
                           input bit typed, input htfd_out_t want);
    htfd_in_t  d;
    bit        closed;
    htfd_out_t rd;
    d.rx_byte     = data;
    d.frame_start = start;
    while (tx_idle()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    // hold the byte while the decoder stalls
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    track_byte(d, closed, rd);
    if (closed) pending_readings.push_back(typed ? want : rd);
  endtask

  // Send one complete reply with random raw words; optionally spoil a check byte.
  task automatic send_frame(input bit resync, input bit bad_t, input bit bad_h);
    logic [7:0] bytes [6];
    for (int i = 0; i < 6; i++) bytes[i] = 8'($urandom);
    bytes[2] = crc8_step(crc8_step(CRC_INIT, bytes[0]), bytes[1]);
    bytes[5] = crc8_step(crc8_step(CRC_INIT, bytes[3]), bytes[4]);
    if (bad_t) bytes[2] ^= 8'($urandom_range(1, 255));
    if (bad_h) bytes[5] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < 6; i++) send_byte(bytes[i], resync && (i == 0), 1'b0, NO_READ);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: compare each transfer with the oldest pending reading, then
  // choose the stall for the next cycle. The hold-off lets the result
  // register fill so the decoder must stall its input.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;

  task automatic check_reading(input htfd_out_t got);
    htfd_out_t want;
    if (pending_readings.size() == 0) begin
      $display("%0t: unexpected reading temp=%0d hum=%0d status=%0b",
               $time, got.temp_centi, got.humidity_centi, got.status);
      mismatch_count++;
      return;
    end
    want = pending_readings.pop_front();
    if (got.temp_centi !== want.temp_centi) begin
      $display("%0t: temp_centi expected %0d, got %0d",
               $time, want.temp_centi, got.temp_centi);
      mismatch_count++;
    end
    if (got.humidity_centi !== want.humidity_centi) begin
      $display("%0t: humidity_centi expected %0d, got %0d",
               $time, want.humidity_centi, got.humidity_centi);
      mismatch_count++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status expected %0b, got %0b", $time, want.status, got.status);
      mismatch_count++;
    end
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) check_reading(out_data_o);
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (items_sent >= RX_QUIET_LO && items_sent < RX_QUIET_HI) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run if it drags far past any correct run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random traffic, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    int kind;
    bit synced;
    int part_len;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_byte(dir_rows[r].rx_byte, dir_rows[r].frame_start,
                dir_rows[r].typed, dir_rows[r].want);
    end

    // Mostly clean replies with random content; some spoiled checks,
    // abandoned frames and stray bytes. Resync after anything misaligned.
    synced = 1'b1;
    while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        send_frame(!synced || $urandom_range(0, 1), $urandom_range(0, 9) == 0,
                   $urandom_range(0, 9) == 0);
        synced = 1'b1;
      end else if (kind < 90) begin
        part_len = $urandom_range(1, 5);
        for (int i = 0; i < part_len; i++) begin
          send_byte(8'($urandom), i == 0, 1'b0, NO_READ);
        end
        synced = 1'b0;
      end else begin
        send_byte(8'($urandom), 1'($urandom), 1'b0, NO_READ);
        synced = 1'b0;
      end
    end
    if (!synced) send_frame(1'b1, 1'b0, 1'b0);

    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
